[design/ocd_pkg.sv]
// opcode class decoder package: widths, result type and the ordered pattern table
// no dependencies; used by every module of the decoder
package ocd_pkg;

   localparam int WORD_W      = 16;
   localparam int CLASS_W     = 7;
   localparam int NUM_CLASSES = 104;

   localparam logic [CLASS_W-1:0] UNKNOWN_CLASS = 7'd104;
   localparam logic [CLASS_W-1:0] CLASS_NOP     = 7'd0;

   typedef struct packed {
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] value;
   } pattern_type;

   typedef struct packed {
      logic [CLASS_W-1:0] class_id;
      logic               is_known;
   } result_type;

   typedef logic [NUM_CLASSES-1:0] match_vec_type;

   // priority order, lowest index wins
   localparam pattern_type PATTERNS [NUM_CLASSES] = '{
      // exact system opcodes
      '{16'hFFFF, 16'h0000}, '{16'hFFFF, 16'h0001}, '{16'hFFFF, 16'h0002},
      '{16'hFFFF, 16'h0003}, '{16'hFFFF, 16'h0008}, '{16'hFFFF, 16'h0009},
      '{16'hFFFF, 16'h000C},
      // register forms
      '{16'hFFF0, 16'h0010}, '{16'hFFF0, 16'h0020}, '{16'hFFF0, 16'h0030},
      '{16'hFFE0, 16'h0040}, '{16'hFFE0, 16'h0060}, '{16'hFF80, 16'h0080},
      '{16'hFF00, 16'h0100}, '{16'hFFE0, 16'h0200}, '{16'hFFE0, 16'h0220},
      '{16'hFFF0, 16'h0240}, '{16'hFFF0, 16'h0250}, '{16'hFFF0, 16'h0260},
      '{16'hFFF8, 16'h0270}, '{16'hFFF8, 16'h0278}, '{16'hFF80, 16'h0280},
      '{16'hFFE0, 16'h0300}, '{16'hFFE0, 16'h0320}, '{16'hFFC0, 16'h0340},
      '{16'hFFE0, 16'h0380}, '{16'hFFE0, 16'h03A0}, '{16'hFFF8, 16'h03C0},
      '{16'hFFF8, 16'h03C8},
      '{16'hFC00, 16'h0400}, '{16'hFF80, 16'h0800}, '{16'hFF80, 16'h0880},
      '{16'hFFC0, 16'h0900}, '{16'hFFC0, 16'h0940}, '{16'hFFC0, 16'h0980},
      '{16'hFFC0, 16'h09C0}, '{16'hFF80, 16'h0A00}, '{16'hFFC0, 16'h0A80},
      '{16'hFFC0, 16'h0AC0},
      '{16'hFFC0, 16'h0B00}, '{16'hFFE0, 16'h0B40}, '{16'hFFE0, 16'h0B80},
      '{16'hFFE0, 16'h0BA0}, '{16'hFFE0, 16'h0BC0}, '{16'hFFE0, 16'h0BE0},
      '{16'hF800, 16'h1000}, '{16'hF800, 16'h1800},
      // conditional branches
      '{16'hFE00, 16'h2000}, '{16'hFE00, 16'h2200}, '{16'hFE00, 16'h2400},
      '{16'hFE00, 16'h2600}, '{16'hFE00, 16'h2800}, '{16'hFE00, 16'h2A00},
      '{16'hFE00, 16'h2C00}, '{16'hFE00, 16'h2E00}, '{16'hFE00, 16'h3000},
      '{16'hFE00, 16'h3200}, '{16'hFE00, 16'h3400}, '{16'hFE00, 16'h3600},
      '{16'hFE00, 16'h3800}, '{16'hFE00, 16'h3A00}, '{16'hFE00, 16'h3C00},
      '{16'hFE00, 16'h3E00},
      // alu
      '{16'hFC00, 16'h4000}, '{16'hFC00, 16'h4400}, '{16'hFC00, 16'h4800},
      '{16'hFC00, 16'h4C00}, '{16'hFC00, 16'h5000}, '{16'hFC00, 16'h5400},
      '{16'hFC00, 16'h5800}, '{16'hFC00, 16'h5C00},
      // shifts
      '{16'hFC00, 16'h6000}, '{16'hFC00, 16'h6400}, '{16'hFC00, 16'h6800},
      '{16'hFC00, 16'h6C00}, '{16'hFC00, 16'h7000}, '{16'hFC00, 16'h7400},
      // load/store
      '{16'hFE00, 16'h7800}, '{16'hFE00, 16'h7A00}, '{16'hFC00, 16'h7C00},
      '{16'hFC00, 16'h8000}, '{16'hFC00, 16'h8400}, '{16'hFC00, 16'h8800},
      '{16'hFC00, 16'h8C00}, '{16'hFE00, 16'h9000}, '{16'hFE00, 16'h9200},
      '{16'hFC00, 16'h9400}, '{16'hFC00, 16'h9800}, '{16'hFE00, 16'h9C00},
      '{16'hFE00, 16'h9E00},
      // literal forms, short and long
      '{16'hF000, 16'hA000}, '{16'hF000, 16'hB000}, '{16'hF800, 16'hC000},
      '{16'hF800, 16'hC800}, '{16'hF800, 16'hD000}, '{16'hF800, 16'hD800},
      '{16'hFC00, 16'hE000}, '{16'hFC00, 16'hE400}, '{16'hF800, 16'hE800},
      '{16'hF800, 16'hF000}, '{16'hFC00, 16'hF800}, '{16'hFC00, 16'hFC00},
      // br and loop
      '{16'hFE00, 16'h0C00}, '{16'hFE00, 16'h0E00}
   };

endpackage

[design/ocd_match.sv]
// opcode class decoder: parallel mask-and-compare against every pattern
// depends on ocd_pkg
module ocd_match (
   input  logic [ocd_pkg::WORD_W-1:0] word,
   output ocd_pkg::match_vec_type     hits
);

   always_comb begin
      for (int i = 0; i < ocd_pkg::NUM_CLASSES; i++) begin
         hits[i] = ((word & ocd_pkg::PATTERNS[i].mask) == ocd_pkg::PATTERNS[i].value);
      end
   end

endmodule

[design/ocd_prio.sv]
// opcode class decoder: priority encoder, lowest matching pattern wins
// depends on ocd_pkg
module ocd_prio (
   input  ocd_pkg::match_vec_type hits,
   output ocd_pkg::result_type    result
);

   always_comb begin
      result.class_id = ocd_pkg::UNKNOWN_CLASS;
      result.is_known = 1'b0;
      // walk downward so the lowest hit is written last
      for (int i = ocd_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
         if (hits[i]) begin
            result.class_id = ocd_pkg::CLASS_W'(i);
            result.is_known = 1'b1;
         end
      end
   end

endmodule

[design/opcode_class_decoder_unit.sv]
// opcode class decoder top level: input register, matcher, priority encoder, result register
// depends on ocd_pkg, ocd_match and ocd_prio
// result path: the accepted item passes the input register, then the result register
// throughput: one item per cycle; busy is never raised, the receiver cannot stall
// reset: synchronous, clears both valid flags; payload registers are not reset
module opcode_class_decoder_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ocd_pkg::WORD_W-1:0]  req_instr_word,
   output logic                        rsp_valid,
   output logic [ocd_pkg::CLASS_W-1:0] rsp_class_id,
   output logic                        rsp_is_known
);

   // input stage
   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [ocd_pkg::WORD_W-1:0] in_word_ff;

   // decode between the two register banks
   ocd_pkg::match_vec_type hits;
   ocd_pkg::result_type    decoded;

   // result stage
   logic                out_valid_ff;
   ocd_pkg::result_type out_result_ff;

   // every cycle is free for a new item: nothing here iterates
   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= in_valid_ff;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_word_ff <= req_instr_word;
      end
      if (in_valid_ff) begin
         out_result_ff <= decoded;
      end
   end

   // all 104 patterns compared side by side
   ocd_match u_match (
      .word (in_word_ff),
      .hits (hits)
   );

   // first hit in list order gives the class
   ocd_prio u_prio (
      .hits   (hits),
      .result (decoded)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_class_id = out_result_ff.class_id;
   assign rsp_is_known = out_result_ff.is_known;

endmodule

[design/ocd_checker.sv]
// opcode class decoder port checker and its bind to the top level
// depends on ocd_pkg and opcode_class_decoder_unit
module ocd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [ocd_pkg::WORD_W-1:0]  req_instr_word,
   input logic                        rsp_valid,
   input logic [ocd_pkg::CLASS_W-1:0] rsp_class_id,
   input logic                        rsp_is_known
);

   // each accepted item yields one result strobe
   a_item_to_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted item gave no result");

   // no strobe without an earlier accepted item
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   // known flag agrees with the class index
   a_known_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_known == (rsp_class_id != ocd_pkg::UNKNOWN_CLASS)))
      else $error("is_known disagrees with class_id");

   // the all-zero word is the highest priority class
   a_nop_class : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_instr_word == '0) |-> ##2 (rsp_class_id == ocd_pkg::CLASS_NOP))
      else $error("zero word not decoded as first class");

endmodule

bind opcode_class_decoder_unit ocd_checker u_ocd_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_instr_word (req_instr_word),
   .rsp_valid      (rsp_valid),
   .rsp_class_id   (rsp_class_id),
   .rsp_is_known   (rsp_is_known)
);

[tb/sv/opcode_class_decoder_unit_tb.sv]
// self-checking testbench for opcode_class_decoder_unit: driven word stream, scoreboard of
// predicted instruction classes checked against every result strobe
// depends on ocd_pkg (widths, result type, unknown class code) and the decoder top level
module opcode_class_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM      = 1350;
   localparam int QUIET_FROM    = 500;    // no idling while this many..QUIET_TO items are in
   localparam int QUIET_TO      = 700;
   localparam int DRAIN_AT      = 900;    // random item that waits for an empty scoreboard
   localparam int IDLE_PERCENT  = 18;
   localparam int SETTLE_CYCLES = 8;      // margin after the last result

   // decode rules as {mask, value}, lowest index has priority
   localparam logic [31:0] DECODE_RULES [ocd_pkg::NUM_CLASSES] = '{
      // exact system opcodes
      32'hFFFF_0000, 32'hFFFF_0001, 32'hFFFF_0002, 32'hFFFF_0003,
      32'hFFFF_0008, 32'hFFFF_0009, 32'hFFFF_000C,
      // register forms
      32'hFFF0_0010, 32'hFFF0_0020, 32'hFFF0_0030,
      32'hFFE0_0040, 32'hFFE0_0060, 32'hFF80_0080,
      32'hFF00_0100, 32'hFFE0_0200, 32'hFFE0_0220,
      32'hFFF0_0240, 32'hFFF0_0250, 32'hFFF0_0260,
      32'hFFF8_0270, 32'hFFF8_0278, 32'hFF80_0280,
      32'hFFE0_0300, 32'hFFE0_0320, 32'hFFC0_0340,
      32'hFFE0_0380, 32'hFFE0_03A0, 32'hFFF8_03C0, 32'hFFF8_03C8,
      32'hFC00_0400, 32'hFF80_0800, 32'hFF80_0880,
      32'hFFC0_0900, 32'hFFC0_0940, 32'hFFC0_0980, 32'hFFC0_09C0,
      32'hFF80_0A00, 32'hFFC0_0A80, 32'hFFC0_0AC0,
      32'hFFC0_0B00, 32'hFFE0_0B40, 32'hFFE0_0B80,
      32'hFFE0_0BA0, 32'hFFE0_0BC0, 32'hFFE0_0BE0,
      32'hF800_1000, 32'hF800_1800,
      // sixteen branch conditions, all reachable under the seven-bit mask
      32'hFE00_2000, 32'hFE00_2200, 32'hFE00_2400, 32'hFE00_2600,
      32'hFE00_2800, 32'hFE00_2A00, 32'hFE00_2C00, 32'hFE00_2E00,
      32'hFE00_3000, 32'hFE00_3200, 32'hFE00_3400, 32'hFE00_3600,
      32'hFE00_3800, 32'hFE00_3A00, 32'hFE00_3C00, 32'hFE00_3E00,
      // alu
      32'hFC00_4000, 32'hFC00_4400, 32'hFC00_4800, 32'hFC00_4C00,
      32'hFC00_5000, 32'hFC00_5400, 32'hFC00_5800, 32'hFC00_5C00,
      // shifts
      32'hFC00_6000, 32'hFC00_6400, 32'hFC00_6800,
      32'hFC00_6C00, 32'hFC00_7000, 32'hFC00_7400,
      // load/store
      32'hFE00_7800, 32'hFE00_7A00, 32'hFC00_7C00,
      32'hFC00_8000, 32'hFC00_8400, 32'hFC00_8800, 32'hFC00_8C00,
      32'hFE00_9000, 32'hFE00_9200, 32'hFC00_9400, 32'hFC00_9800,
      32'hFE00_9C00, 32'hFE00_9E00,
      // literal forms, short then long
      32'hF000_A000, 32'hF000_B000, 32'hF800_C000,
      32'hF800_C800, 32'hF800_D000, 32'hF800_D800,
      32'hFC00_E000, 32'hFC00_E400, 32'hF800_E800,
      32'hF800_F000, 32'hFC00_F800, 32'hFC00_FC00,
      // br and loop
      32'hFE00_0C00, 32'hFE00_0E00
   };

   // directed words: field extremes, every system opcode, holes in the map, odd branch
   // conditions, br and loop, short and long literals
   localparam logic [ocd_pkg::WORD_W-1:0] DIRECTED_WORDS [24] = '{
      16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0008, 16'h0009, 16'h000C,
      16'h0004, 16'h000F, 16'h03D0, 16'h0B60, 16'h03FF,
      16'hFFFF, 16'h2200, 16'h3FFF, 16'h0C00, 16'h0FFF, 16'h0E00,
      16'hA000, 16'hBFFF, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA
   };

   typedef struct {
      logic [ocd_pkg::WORD_W-1:0] word;
      bit                         drain_first;   // hold off until every earlier result has come
   } fetch_item_type;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        start          = 1'b0;
   logic                        busy;
   logic [ocd_pkg::WORD_W-1:0]  req_instr_word = '0;
   logic                        rsp_valid;
   logic [ocd_pkg::CLASS_W-1:0] rsp_class_id;
   logic                        rsp_is_known;

   fetch_item_type      fetch_words [$];        // items waiting to be driven
   ocd_pkg::result_type expected_classes [$];   // predicted results, oldest first
   int                  n_issued     = 0;
   int                  results_seen = 0;
   int                  n_errors     = 0;

   opcode_class_decoder_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_instr_word (req_instr_word),
      .rsp_valid      (rsp_valid),
      .rsp_class_id   (rsp_class_id),
      .rsp_is_known   (rsp_is_known)
   );

   always #5 clock = ~clock;

   // first matching rule wins; scanning from the top leaves the lowest match standing
   function automatic ocd_pkg::result_type classify_word(
      input logic [ocd_pkg::WORD_W-1:0] word);
      ocd_pkg::result_type r;
      r.class_id = ocd_pkg::UNKNOWN_CLASS;
      r.is_known = 1'b0;
      for (int i = ocd_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
         if ((word & DECODE_RULES[i][31:16]) == DECODE_RULES[i][15:0]) begin
            r.class_id = ocd_pkg::CLASS_W'(i);
            r.is_known = 1'b1;
         end
      end
      return r;
   endfunction

   // driver: an item is taken at an edge with start high and busy low
   always @(posedge clock) begin : driver
      fetch_item_type head;
      bit             taken;
      bit             quiet;
      if (reset) begin
         start          <= 1'b0;
         req_instr_word <= '0;
      end else begin
         taken = start && (busy === 1'b0);
         if (taken) begin
            expected_classes.push_back(classify_word(req_instr_word));
            n_issued++;
         end
         quiet = (n_issued >= QUIET_FROM) && (n_issued < QUIET_TO);
         if (start && !taken) begin
            // item not taken yet, hold it where it is
         end else if (fetch_words.size() > 0
                      && !(fetch_words[0].drain_first && results_seen != n_issued)
                      && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            head = fetch_words.pop_front();
            start          <= 1'b1;
            req_instr_word <= head.word;
         end else begin
            // idle cycle: junk on the word bus must not be picked up
            start          <= 1'b0;
            req_instr_word <= ocd_pkg::WORD_W'($urandom);
         end
      end
   end

   // monitor: sample mid-cycle so the scoreboard never races the driver
   always @(negedge clock) begin : monitor
      ocd_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_classes.size() == 0) begin
               $error("result with no item outstanding: class_id %0d is_known %0b",
                      rsp_class_id, rsp_is_known);
               n_errors++;
            end else begin
               want = expected_classes.pop_front();
               results_seen++;
               if (rsp_class_id !== want.class_id) begin
                  $error("class_id: expected %0d, got %0d", want.class_id, rsp_class_id);
                  n_errors++;
               end
               if (rsp_is_known !== want.is_known) begin
                  $error("is_known: expected %0b, got %0b", want.is_known, rsp_is_known);
                  n_errors++;
               end
            end
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid: expected 0 or 1, got %b", rsp_valid);
            n_errors++;
         end
      end
   end

   initial begin : stimulus
      logic [31:0]                rule;
      logic [ocd_pkg::WORD_W-1:0] word;
      int                         roll;

      foreach (DIRECTED_WORDS[i])
         fetch_words.push_back(fetch_item_type'{word: DIRECTED_WORDS[i], drain_first: 1'b0});

      // mostly words aimed at one class with random operand bits, mixed with plain noise
      // and near misses with one bit flipped, which may land in the holes of the map
      for (int n = 0; n < N_RANDOM; n++) begin
         rule = DECODE_RULES[$urandom_range(0, ocd_pkg::NUM_CLASSES - 1)];
         word = rule[15:0] | (ocd_pkg::WORD_W'($urandom) & ~rule[31:16]);
         roll = $urandom_range(0, 99);
         if (roll < 25)
            word = ocd_pkg::WORD_W'($urandom);
         else if (roll < 40)
            word ^= ocd_pkg::WORD_W'(1) << $urandom_range(0, ocd_pkg::WORD_W - 1);
         fetch_words.push_back(fetch_item_type'{word: word,
                                                drain_first: (n == 0 || n == DRAIN_AT)});
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // everything taken and every prediction answered
      do @(negedge clock);
      while (fetch_words.size() != 0 || start || results_seen != n_issued);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (n_errors == 0)
         $display("opcode_class_decoder_unit: match");
      else
         $display("opcode_class_decoder_unit: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("opcode_class_decoder_unit: mismatch");
      $finish;
   end

endmodule

[filelist.f]
design/ocd_pkg.sv
design/ocd_match.sv
design/ocd_prio.sv
design/opcode_class_decoder_unit.sv
design/ocd_checker.sv
tb/sv/opcode_class_decoder_unit_tb.sv
